[src/llr_pkg.sv]
package llr_pkg;

  localparam int FracBits = 16;
  localparam int Dim      = 2;

  localparam int InW   = 32;
  localparam int DiffW = InW + 1;
  localparam int ProdW = InW + DiffW;
  localparam int SumW  = ProdW + 1;
  localparam int DyW   = SumW - FracBits - 1;
  localparam int NumW  = DyW + 1;
  localparam int RemW  = NumW + 1;
  localparam int RatW  = FracBits + 1;
  localparam int PhiQW = FracBits + 3;
  localparam int PhiW  = FracBits + 1;

  localparam int SquareStage = FracBits + 1;
  localparam int LimStages   = SquareStage + 1 + PhiQW;

  localparam int LoW = DyW / 2;
  localparam int HiW = DyW - LoW;
  localparam int PW  = PhiW + 1 + DyW;
  localparam int TW  = PW - FracBits;

  typedef struct packed {
    logic signed [InW-1:0] pos_i_x;
    logic signed [InW-1:0] pos_i_y;
    logic signed [InW-1:0] pos_j_x;
    logic signed [InW-1:0] pos_j_y;
    logic signed [InW-1:0] value_i;
    logic signed [InW-1:0] value_j;
    logic signed [InW-1:0] grad_i_x;
    logic signed [InW-1:0] grad_i_y;
    logic signed [InW-1:0] grad_j_x;
    logic signed [InW-1:0] grad_j_y;
  } in_req_t;

  typedef struct packed {
    logic signed [InW-1:0] recon_i;
    logic signed [InW-1:0] recon_j;
    logic                  saturated;
  } out_rsp_t;

  typedef struct packed {
    logic signed [DyW-1:0] dy_i;
    logic signed [DyW-1:0] dy_j;
    logic signed [InW-1:0] value_i;
    logic signed [InW-1:0] value_j;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic signed [DiffW-1:0] dy0;
  } dot_t;

  // one divider lane: shared by the ratio divide and the limiter divide
  typedef struct packed {
    logic             zero;
    logic [NumW-1:0]  den;
    logic [RemW-1:0]  rem;
    logic [PhiQW-1:0] quo;
    logic [PhiQW-1:0] num;
  } lane_t;

  typedef struct packed {
    lane_t lane_i;
    lane_t lane_j;
    side_t side;
  } lim_t;

endpackage

[src/limited_linear_reconstruction.sv]
// Van Leer limited linear reconstruction of a field between two particles.
// One particle pair is taken per cycle when not stalled, and results leave
// in order, one per pair. A pair passes through the separation and half dot
// products, then the limiter (two restoring dividers at one quotient bit
// per stage, the ratio divide and the 4r/(1+r)^2 divide, with the square
// between them), then averaging, the scaled correction and saturation.
// Every stage holds its own valid bit, so bubbles fill up when the output is
// stalled and new requests are still taken until the pipeline is full.
module limited_linear_reconstruction (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  llr_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output llr_pkg::out_rsp_t out_rsp_o
);

  logic          dot_valid, dot_stall;
  llr_pkg::dot_t dot;
  logic          lim_valid, lim_stall;
  llr_pkg::lim_t lim;

  llr_dot u_dot (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (dot_valid),
    .out_stall_i (dot_stall),
    .out_dot_o   (dot)
  );

  llr_limit u_limit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dot_valid),
    .in_stall_o  (dot_stall),
    .in_dot_i    (dot),
    .out_valid_o (lim_valid),
    .out_stall_i (lim_stall),
    .out_lim_o   (lim)
  );

  llr_recon u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lim_valid),
    .in_stall_o  (lim_stall),
    .in_lim_i    (lim),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

[src/llr_dot.sv]
module llr_dot (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  llr_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output llr_pkg::dot_t     out_dot_o
);

  localparam int N = 3;

  logic         v_q [N];
  logic [N:0]   en;

  logic signed [llr_pkg::DiffW-1:0] rx_q, ry_q, dy0_q, dy0_1_q;
  logic signed [llr_pkg::InW-1:0]   gix_q, giy_q, gjx_q, gjy_q;
  logic signed [llr_pkg::InW-1:0]   vi_q, vj_q, vi_1_q, vj_1_q;
  logic signed [llr_pkg::ProdW-1:0] pix_q, piy_q, pjx_q, pjy_q;
  logic signed [llr_pkg::ProdW-1:0] pix_d, piy_d, pjx_d, pjy_d;
  logic signed [llr_pkg::SumW-1:0]  si_d, sj_d;
  llr_pkg::dot_t                    dot_q;
  logic signed [llr_pkg::DiffW-1:0] rx_d, ry_d, dy0_d;

  always_comb begin
    en[N] = !out_stall_i;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[N-1];
  assign out_dot_o   = dot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) v_q[k] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // separation and value difference
  always_comb begin
    rx_d  = $signed({in_req_i.pos_i_x[llr_pkg::InW-1], in_req_i.pos_i_x})
          - $signed({in_req_i.pos_j_x[llr_pkg::InW-1], in_req_i.pos_j_x});
    ry_d  = $signed({in_req_i.pos_i_y[llr_pkg::InW-1], in_req_i.pos_i_y})
          - $signed({in_req_i.pos_j_y[llr_pkg::InW-1], in_req_i.pos_j_y});
    dy0_d = $signed({in_req_i.value_i[llr_pkg::InW-1], in_req_i.value_i})
          - $signed({in_req_i.value_j[llr_pkg::InW-1], in_req_i.value_j});
    if (llr_pkg::Dim < 2) ry_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      dy0_q <= dy0_d;
      gix_q <= in_req_i.grad_i_x;
      giy_q <= (llr_pkg::Dim < 2) ? '0 : in_req_i.grad_i_y;
      gjx_q <= in_req_i.grad_j_x;
      gjy_q <= (llr_pkg::Dim < 2) ? '0 : in_req_i.grad_j_y;
      vi_q  <= in_req_i.value_i;
      vj_q  <= in_req_i.value_j;
    end
  end

  assign pix_d = gix_q * rx_q;
  assign piy_d = giy_q * ry_q;
  assign pjx_d = gjx_q * rx_q;
  assign pjy_d = gjy_q * ry_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pix_q   <= pix_d;
      piy_q   <= piy_d;
      pjx_q   <= pjx_d;
      pjy_q   <= pjy_d;
      dy0_1_q <= dy0_q;
      vi_1_q  <= vi_q;
      vj_1_q  <= vj_q;
    end
  end

  assign si_d = llr_pkg::SumW'(pix_q) + llr_pkg::SumW'(piy_q);
  assign sj_d = llr_pkg::SumW'(pjx_q) + llr_pkg::SumW'(pjy_q);

  // half dot product, floored
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dot_q.side.dy_i    <= llr_pkg::DyW'(si_d >>> (llr_pkg::FracBits + 1));
      dot_q.side.dy_j    <= llr_pkg::DyW'(sj_d >>> (llr_pkg::FracBits + 1));
      dot_q.side.value_i <= vi_1_q;
      dot_q.side.value_j <= vj_1_q;
      dot_q.dy0          <= dy0_1_q;
    end
  end

endmodule

[src/llr_limit.sv]
module llr_limit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  llr_pkg::dot_t  in_dot_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output llr_pkg::lim_t  out_lim_o
);

  localparam int S = llr_pkg::LimStages;

  logic                  v_q    [S];
  logic [S:0]            en;
  llr_pkg::lane_t [1:0]  lane_q [S];
  llr_pkg::side_t        side_q [S];

  // magnitudes, zero-limiter flag, first quotient bit of min/max
  function automatic llr_pkg::lane_t prep(input logic signed [llr_pkg::DyW-1:0]   dy,
                                          input logic signed [llr_pkg::DiffW-1:0] dy0);
    logic                      neg0, negy;
    logic [llr_pkg::DiffW-1:0] raw0, dmag;
    logic [llr_pkg::DyW-1:0]   rawy, ymag;
    logic [llr_pkg::NumW-1:0]  d, n, a, b;
    llr_pkg::lane_t            o;
    raw0 = dy0;
    rawy = dy;
    neg0 = raw0[llr_pkg::DiffW-1];
    negy = rawy[llr_pkg::DyW-1];
    dmag = neg0 ? (~raw0 + llr_pkg::DiffW'(1)) : raw0;
    ymag = negy ? (~rawy + llr_pkg::DyW'(1)) : rawy;
    d = llr_pkg::NumW'(dmag);
    if (d == '0) d = llr_pkg::NumW'(1);
    n = {ymag, 1'b0};
    a = (n < d) ? n : d;
    b = (n < d) ? d : n;
    o.zero = (rawy == '0) || (negy != neg0);
    o.den  = b;
    o.rem  = (a == b) ? '0 : llr_pkg::RemW'(a);
    o.quo  = llr_pkg::PhiQW'(a == b);
    o.num  = '0;
    return o;
  endfunction

  // one restoring division step
  function automatic llr_pkg::lane_t step(input llr_pkg::lane_t l);
    logic [llr_pkg::RemW-1:0] rem2, den;
    logic                     ge;
    llr_pkg::lane_t           o;
    rem2   = {l.rem[llr_pkg::RemW-2:0], l.num[llr_pkg::PhiQW-1]};
    den    = llr_pkg::RemW'(l.den);
    ge     = rem2 >= den;
    o.zero = l.zero;
    o.den  = l.den;
    o.rem  = ge ? rem2 - den : rem2;
    o.quo  = {l.quo[llr_pkg::PhiQW-2:0], ge};
    o.num  = {l.num[llr_pkg::PhiQW-2:0], 1'b0};
    return o;
  endfunction

  // q = (1+r)^2, then set up 4r / q
  function automatic llr_pkg::lane_t square(input llr_pkg::lane_t l);
    logic [llr_pkg::RatW-1:0]   r;
    logic [llr_pkg::RatW:0]     op;
    logic [2*llr_pkg::RatW+1:0] sq;
    llr_pkg::lane_t             o;
    r      = l.quo[llr_pkg::RatW-1:0];
    op     = {1'b0, r} + ((llr_pkg::RatW+1)'(1) << llr_pkg::FracBits);
    sq     = (2*llr_pkg::RatW+2)'(op) * (2*llr_pkg::RatW+2)'(op);
    o.zero = l.zero;
    o.den  = llr_pkg::NumW'(sq >> llr_pkg::FracBits);
    o.rem  = llr_pkg::RemW'(r >> 1);
    o.quo  = '0;
    o.num  = {r[0], (llr_pkg::PhiQW-1)'(0)};
    return o;
  endfunction

  always_comb begin
    en[S] = !out_stall_i;
    for (int k = S - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o       = !en[0];
  assign out_valid_o      = v_q[S-1];
  assign out_lim_o.lane_i = lane_q[S-1][0];
  assign out_lim_o.lane_j = lane_q[S-1][1];
  assign out_lim_o.side   = side_q[S-1];

  for (genvar s = 0; s < S; s++) begin : g_stage
    llr_pkg::lane_t [1:0] lane_d;
    llr_pkg::side_t       side_d;
    logic                 v_d;

    if (s == 0) begin : g_prep
      assign lane_d[0] = prep(in_dot_i.side.dy_i, in_dot_i.dy0);
      assign lane_d[1] = prep(in_dot_i.side.dy_j, in_dot_i.dy0);
      assign side_d    = in_dot_i.side;
      assign v_d       = in_valid_i;
    end else if (s == llr_pkg::SquareStage) begin : g_square
      assign lane_d[0] = square(lane_q[s-1][0]);
      assign lane_d[1] = square(lane_q[s-1][1]);
      assign side_d    = side_q[s-1];
      assign v_d       = v_q[s-1];
    end else begin : g_step
      assign lane_d[0] = step(lane_q[s-1][0]);
      assign lane_d[1] = step(lane_q[s-1][1]);
      assign side_d    = side_q[s-1];
      assign v_d       = v_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en[s]) begin
        v_q[s] <= v_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s]) begin
        lane_q[s] <= lane_d;
        side_q[s] <= side_d;
      end
    end
  end

endmodule

[src/llr_recon.sv]
module llr_recon (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  llr_pkg::lim_t     in_lim_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output llr_pkg::out_rsp_t out_rsp_o
);

  localparam int N = 4;

  logic       v_q [N];
  logic [N:0] en;

  logic [llr_pkg::PhiW-1:0]             phi_q, cap_i, cap_j;
  logic [llr_pkg::PhiW:0]               phi_sum;
  llr_pkg::side_t                       side0_q;
  logic signed [llr_pkg::InW-1:0]       vi1_q, vj1_q, vi2_q, vj2_q;
  logic [llr_pkg::PhiW+llr_pkg::LoW-1:0] loi_q, loj_q;
  logic signed [llr_pkg::PhiW+llr_pkg::HiW:0] hii_q, hij_q;
  logic signed [llr_pkg::HiW-1:0]       dyhi_i, dyhi_j;
  logic signed [llr_pkg::PW-1:0]        prod_i, prod_j;
  logic signed [llr_pkg::TW-1:0]        ti_q, tj_q;
  logic signed [llr_pkg::TW:0]          oi, oj;
  logic [llr_pkg::InW:0]                ci, cj;
  llr_pkg::out_rsp_t                    rsp_q;

  function automatic logic [llr_pkg::PhiW-1:0] cap(input llr_pkg::lane_t l);
    logic [llr_pkg::PhiQW-1:0] one;
    one = llr_pkg::PhiQW'(1) << llr_pkg::FracBits;
    if (l.zero) return '0;
    return (l.quo > one) ? llr_pkg::PhiW'(one) : llr_pkg::PhiW'(l.quo);
  endfunction

  // returns {clipped, value}
  function automatic logic [llr_pkg::InW:0] clamp(input logic signed [llr_pkg::TW:0] v);
    logic [llr_pkg::TW:0] u;
    u = v;
    if (u[llr_pkg::TW:llr_pkg::InW-1] == '0 || u[llr_pkg::TW:llr_pkg::InW-1] == '1) begin
      return {1'b0, u[llr_pkg::InW-1:0]};
    end
    return u[llr_pkg::TW] ? {1'b1, 1'b1, (llr_pkg::InW-1)'(0)}
                          : {1'b1, 1'b0, {(llr_pkg::InW-1){1'b1}}};
  endfunction

  always_comb begin
    en[N] = !out_stall_i;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[N-1];
  assign out_rsp_o   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) v_q[k] <= 1'b0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < N; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // cap and average the two limiters
  assign cap_i   = cap(in_lim_i.lane_i);
  assign cap_j   = cap(in_lim_i.lane_j);
  assign phi_sum = {1'b0, cap_i} + {1'b0, cap_j};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      phi_q   <= phi_sum[llr_pkg::PhiW:1];
      side0_q <= in_lim_i.side;
    end
  end

  // phi * dy split into two partial products
  assign dyhi_i = side0_q.dy_i[llr_pkg::DyW-1:llr_pkg::LoW];
  assign dyhi_j = side0_q.dy_j[llr_pkg::DyW-1:llr_pkg::LoW];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      loi_q <= (llr_pkg::PhiW+llr_pkg::LoW)'(phi_q)
             * (llr_pkg::PhiW+llr_pkg::LoW)'(side0_q.dy_i[llr_pkg::LoW-1:0]);
      loj_q <= (llr_pkg::PhiW+llr_pkg::LoW)'(phi_q)
             * (llr_pkg::PhiW+llr_pkg::LoW)'(side0_q.dy_j[llr_pkg::LoW-1:0]);
      hii_q <= $signed({1'b0, phi_q}) * dyhi_i;
      hij_q <= $signed({1'b0, phi_q}) * dyhi_j;
      vi1_q <= side0_q.value_i;
      vj1_q <= side0_q.value_j;
    end
  end

  assign prod_i = (llr_pkg::PW'(hii_q) <<< llr_pkg::LoW) + llr_pkg::PW'($signed({1'b0, loi_q}));
  assign prod_j = (llr_pkg::PW'(hij_q) <<< llr_pkg::LoW) + llr_pkg::PW'($signed({1'b0, loj_q}));

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      ti_q  <= llr_pkg::TW'(prod_i >>> llr_pkg::FracBits);
      tj_q  <= llr_pkg::TW'(prod_j >>> llr_pkg::FracBits);
      vi2_q <= vi1_q;
      vj2_q <= vj1_q;
    end
  end

  assign oi = (llr_pkg::TW+1)'(vi2_q) - (llr_pkg::TW+1)'(ti_q);
  assign oj = (llr_pkg::TW+1)'(vj2_q) + (llr_pkg::TW+1)'(tj_q);
  assign ci = clamp(oi);
  assign cj = clamp(oj);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      rsp_q.recon_i   <= ci[llr_pkg::InW-1:0];
      rsp_q.recon_j   <= cj[llr_pkg::InW-1:0];
      rsp_q.saturated <= ci[llr_pkg::InW] | cj[llr_pkg::InW];
    end
  end

endmodule
